// File: src/record_ring_out_of_order_retire_unit_macros.svh
// ----------------------------------------------------------------------------
// record ring assertion macros
// shared concurrent assertion forms, sampled on clock, off while in reset
// ----------------------------------------------------------------------------
`ifndef RECORD_RING_OUT_OF_ORDER_RETIRE_UNIT_MACROS_SVH
`define RECORD_RING_OUT_OF_ORDER_RETIRE_UNIT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define RR_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define RR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/rrooru_pkg.sv
// ----------------------------------------------------------------------------
// rrooru_pkg
// codes, word types and controller/datapath link types for the record ring
// ----------------------------------------------------------------------------
package rrooru_pkg;

   localparam logic [2:0] CMD_SAVE     = 3'd0;
   localparam logic [2:0] CMD_RELEASE  = 3'd1;
   localparam logic [2:0] CMD_FIRST    = 3'd2;
   localparam logic [2:0] CMD_NEXT     = 3'd3;
   localparam logic [2:0] CMD_IS_EMPTY = 3'd4;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
   localparam logic [1:0] STATUS_NOT_NEW   = 2'd2;
   localparam logic [1:0] STATUS_INVALID   = 2'd3;

   localparam logic [1:0] MARK_ABSENT = 2'd0;
   localparam logic [1:0] MARK_NEW    = 2'd1;
   localparam logic [1:0] MARK_FREED  = 2'd2;

   typedef struct packed {
      logic [2:0] command;
      logic [7:0] slot_index;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] slot_out;
      logic       ring_empty;
   } rsp_type;

   typedef enum logic [1:0] {RD_TAIL, RD_IDX, RD_START, RD_STEP} rd_sel_type;
   typedef enum logic [1:0] {WR_HEAD, WR_IDX, WR_WALK} wr_sel_type;
   typedef enum logic [1:0] {SRC_NONE, SRC_HEAD, SRC_TAIL, SRC_WALK} slot_src_type;

   typedef struct packed {
      logic         load;
      logic         rd_en;
      rd_sel_type   rd_sel;
      logic         wr_en;
      wr_sel_type   wr_sel;
      logic [1:0]   wr_mark;
      logic         walk_start;
      logic         walk_step;
      logic         head_step;
      logic         tail_take;
      logic         res_load;
      logic [1:0]   res_status;
      slot_src_type res_src;
      logic         res_empty;
   } ctl_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic       idx_ok;
      logic       idx_is_tail;
      logic [1:0] mark;
      logic       walk_is_idx;
      logic       out_busy;
   } sts_type;

endpackage

// File: src/record_ring_out_of_order_retire_unit.sv
// ----------------------------------------------------------------------------
// record_ring_out_of_order_retire_unit
// ring of slot marks with save, out-of-order release, first, next and is-empty
// ----------------------------------------------------------------------------
// steps: save, bad codes and out-of-range slots answer from decode; first
// and is_empty read the tail mark; release and next read a mark and may walk
// one word at a time: the next word is accepted in idle, after the result
// is registered; the walk over the marks steps one slot per cycle or stalls
// reset: synchronous, clears head, tail and all slot valid bits at once
// (every slot reads absent), no clearing pass
module record_ring_out_of_order_retire_unit #(
   parameter int SLOTS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  rrooru_pkg::req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rrooru_pkg::rsp_type rsp_data
);
   import rrooru_pkg::*;

   ctl_type ctl;
   sts_type sts;

   rrooru_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .ctl       (ctl),
      .sts       (sts)
   );

   rrooru_datapath #(
      .SLOTS (SLOTS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .ctl       (ctl),
      .sts       (sts),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// File: src/rrooru_ctrl.sv
// ----------------------------------------------------------------------------
// rrooru_ctrl
// sequencer: decodes a command and steps the datapath through reads and walks
// ----------------------------------------------------------------------------
module rrooru_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output rrooru_pkg::ctl_type ctl,
   input  rrooru_pkg::sts_type sts
);
   import rrooru_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_DECODE, ST_REL_CHK, ST_REL_WALK, ST_TAIL_CHK, ST_NEXT_WALK
   } state_type;

   state_type state_ff, state_in;
   ctl_type   ctl_out;

   always_comb begin
      ctl_out  = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctl_out.load = 1'b1;
               state_in     = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (!sts.out_busy) begin
               unique case (sts.cmd) inside
                  CMD_SAVE: begin
                     ctl_out.wr_en      = 1'b1;
                     ctl_out.wr_sel     = WR_HEAD;
                     ctl_out.wr_mark    = MARK_NEW;
                     ctl_out.head_step  = 1'b1;
                     ctl_out.res_load   = 1'b1;
                     ctl_out.res_status = STATUS_OK;
                     ctl_out.res_src    = SRC_HEAD;
                     state_in           = ST_IDLE;
                  end
                  CMD_RELEASE: begin
                     if (!sts.idx_ok) begin
                        ctl_out.res_load   = 1'b1;
                        ctl_out.res_status = STATUS_INVALID;
                        state_in           = ST_IDLE;
                     end else begin
                        ctl_out.rd_en  = 1'b1;
                        ctl_out.rd_sel = RD_IDX;
                        state_in       = ST_REL_CHK;
                     end
                  end
                  CMD_FIRST, CMD_IS_EMPTY: begin
                     ctl_out.rd_en  = 1'b1;
                     ctl_out.rd_sel = RD_TAIL;
                     state_in       = ST_TAIL_CHK;
                  end
                  CMD_NEXT: begin
                     if (!sts.idx_ok) begin
                        ctl_out.res_load   = 1'b1;
                        ctl_out.res_status = STATUS_INVALID;
                        state_in           = ST_IDLE;
                     end else begin
                        ctl_out.rd_en      = 1'b1;
                        ctl_out.rd_sel     = RD_START;
                        ctl_out.walk_start = 1'b1;
                        state_in           = ST_NEXT_WALK;
                     end
                  end
                  default: begin
                     ctl_out.res_load   = 1'b1;
                     ctl_out.res_status = STATUS_INVALID;
                     state_in           = ST_IDLE;
                  end
               endcase
            end
         end
         ST_REL_CHK: begin
            if (!sts.out_busy) begin
               if (!sts.idx_is_tail) begin
                  ctl_out.res_load = 1'b1;
                  state_in         = ST_IDLE;
                  if (sts.mark == MARK_ABSENT) begin
                     ctl_out.res_status = STATUS_NOT_FOUND;
                  end else begin
                     ctl_out.wr_en      = 1'b1;
                     ctl_out.wr_sel     = WR_IDX;
                     ctl_out.wr_mark    = MARK_FREED;
                     ctl_out.res_status = STATUS_OK;
                  end
               end else begin
                  // tail retires whatever its mark, then the walk begins
                  ctl_out.wr_en      = 1'b1;
                  ctl_out.wr_sel     = WR_IDX;
                  ctl_out.wr_mark    = MARK_ABSENT;
                  ctl_out.rd_en      = 1'b1;
                  ctl_out.rd_sel     = RD_START;
                  ctl_out.walk_start = 1'b1;
                  state_in           = ST_REL_WALK;
               end
            end
         end
         ST_REL_WALK: begin
            if (!sts.out_busy) begin
               if (sts.mark == MARK_FREED) begin
                  ctl_out.wr_en     = 1'b1;
                  ctl_out.wr_sel    = WR_WALK;
                  ctl_out.wr_mark   = MARK_ABSENT;
                  ctl_out.rd_en     = 1'b1;
                  ctl_out.rd_sel    = RD_STEP;
                  ctl_out.walk_step = 1'b1;
               end else begin
                  ctl_out.tail_take  = 1'b1;
                  ctl_out.res_load   = 1'b1;
                  ctl_out.res_status = STATUS_OK;
                  state_in           = ST_IDLE;
               end
            end
         end
         ST_TAIL_CHK: begin
            if (!sts.out_busy) begin
               ctl_out.res_load = 1'b1;
               state_in         = ST_IDLE;
               if (sts.cmd == CMD_FIRST) begin
                  case (sts.mark)
                     MARK_NEW: begin
                        ctl_out.res_status = STATUS_OK;
                        ctl_out.res_src    = SRC_TAIL;
                     end
                     MARK_ABSENT: ctl_out.res_status = STATUS_NOT_FOUND;
                     default:     ctl_out.res_status = STATUS_NOT_NEW;
                  endcase
               end else begin
                  case (sts.mark)
                     MARK_NEW:    ctl_out.res_status = STATUS_OK;
                     MARK_ABSENT: begin
                        ctl_out.res_status = STATUS_OK;
                        ctl_out.res_empty  = 1'b1;
                     end
                     default: begin
                        ctl_out.res_status = STATUS_NOT_NEW;
                        ctl_out.res_empty  = 1'b1;
                     end
                  endcase
               end
            end
         end
         ST_NEXT_WALK: begin
            if (!sts.out_busy) begin
               if (sts.mark == MARK_ABSENT) begin
                  ctl_out.res_load   = 1'b1;
                  ctl_out.res_status = STATUS_NOT_FOUND;
                  state_in           = ST_IDLE;
               end else if (sts.mark == MARK_NEW) begin
                  ctl_out.res_load   = 1'b1;
                  ctl_out.res_status = STATUS_OK;
                  ctl_out.res_src    = SRC_WALK;
                  state_in           = ST_IDLE;
               end else if (sts.walk_is_idx) begin
                  // came all the way round to the requested slot
                  ctl_out.res_load   = 1'b1;
                  ctl_out.res_status = STATUS_NOT_FOUND;
                  state_in           = ST_IDLE;
               end else begin
                  ctl_out.rd_en     = 1'b1;
                  ctl_out.rd_sel    = RD_STEP;
                  ctl_out.walk_step = 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign ctl       = ctl_out;
   assign req_stall = (state_ff != ST_IDLE);

endmodule

// File: src/rrooru_datapath.sv
// ----------------------------------------------------------------------------
// rrooru_datapath
// slot mark memory, head/tail/walk indices, request latch and result register
// ----------------------------------------------------------------------------
`include "record_ring_out_of_order_retire_unit_macros.svh"

module rrooru_datapath #(
   parameter int SLOTS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  rrooru_pkg::req_type req_data,
   input  rrooru_pkg::ctl_type ctl,
   output rrooru_pkg::sts_type sts,
   input  logic                rsp_stall,
   output logic                rsp_valid,
   output rrooru_pkg::rsp_type rsp_data
);
   import rrooru_pkg::*;

   localparam int SLOT_W = (SLOTS > 2) ? $clog2(SLOTS) : 1;
   localparam logic [SLOT_W:0] SLOT_COUNT = (SLOT_W + 1)'(SLOTS);

   function automatic logic [SLOT_W-1:0] ring_adv(input logic [SLOT_W-1:0] s);
      logic [SLOT_W:0] nxt;
      nxt = (SLOT_W + 1)'(s) + (SLOT_W + 1)'(1);
      return (nxt >= SLOT_COUNT) ? '0 : nxt[SLOT_W-1:0];
   endfunction

   req_type           req_ff;
   logic [SLOT_W-1:0] head_ff, head_in;
   logic [SLOT_W-1:0] tail_ff, tail_in;
   logic [SLOT_W-1:0] walk_ff, walk_in;
   logic [1:0]        mark_mem [SLOTS];
   logic [SLOTS-1:0]  mark_vld_ff;
   logic [1:0]        mark_rd_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff;
   rsp_type           rsp_data_in;

   logic [SLOT_W-1:0] idx_slot;
   logic [SLOT_W-1:0] idx_start;
   logic [SLOT_W-1:0] walk_next;
   logic [SLOT_W-1:0] rd_addr;
   logic [SLOT_W-1:0] wr_addr;

   assign idx_slot  = req_ff.slot_index[SLOT_W-1:0];
   assign idx_start = ring_adv(idx_slot);
   assign walk_next = ring_adv(walk_ff);

   always_comb begin
      case (ctl.rd_sel)
         RD_TAIL:  rd_addr = tail_ff;
         RD_IDX:   rd_addr = idx_slot;
         RD_START: rd_addr = idx_start;
         RD_STEP:  rd_addr = walk_next;
         default:  rd_addr = tail_ff;
      endcase
   end

   always_comb begin
      case (ctl.wr_sel)
         WR_HEAD: wr_addr = head_ff;
         WR_IDX:  wr_addr = idx_slot;
         WR_WALK: wr_addr = walk_ff;
         default: wr_addr = head_ff;
      endcase
   end

   // an entry never written since reset reads as absent
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mark_mem[wr_addr] <= ctl.wr_mark;
      end
      if (ctl.rd_en) begin
         mark_rd_ff <= mark_vld_ff[rd_addr] ? mark_mem[rd_addr] : MARK_ABSENT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mark_vld_ff <= '0;
      end else if (ctl.wr_en) begin
         mark_vld_ff[wr_addr] <= 1'b1;
      end
   end

   assign head_in = ctl.head_step ? ring_adv(head_ff) : head_ff;
   assign tail_in = ctl.tail_take ? walk_ff : tail_ff;

   always_comb begin
      walk_in = walk_ff;
      if (ctl.walk_start) begin
         walk_in = idx_start;
      end else if (ctl.walk_step) begin
         walk_in = walk_next;
      end
   end

   always_comb begin
      rsp_data_in.status     = ctl.res_status;
      rsp_data_in.ring_empty = ctl.res_empty;
      case (ctl.res_src)
         SRC_HEAD: rsp_data_in.slot_out = 8'(head_ff);
         SRC_TAIL: rsp_data_in.slot_out = 8'(tail_ff);
         SRC_WALK: rsp_data_in.slot_out = 8'(walk_ff);
         default:  rsp_data_in.slot_out = 8'd0;
      endcase
   end

   assign rsp_valid_in = ctl.res_load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         tail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      walk_ff <= walk_in;
      if (ctl.load) begin
         req_ff <= req_data;
      end
      if (ctl.res_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign sts.cmd         = req_ff.command;
   assign sts.idx_ok      = {1'b0, req_ff.slot_index} < 9'(SLOTS);
   assign sts.idx_is_tail = req_ff.slot_index == 8'(tail_ff);
   assign sts.mark        = mark_rd_ff;
   assign sts.walk_is_idx = walk_ff == idx_slot;
   assign sts.out_busy    = rsp_valid_ff & rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `RR_ASSERT_NOW(a_res_into_free, ctl.res_load, !(rsp_valid_ff && rsp_stall), "result over held word")
   `RR_ASSERT_NOW(a_no_rw_clash, ctl.wr_en && ctl.rd_en, wr_addr != rd_addr, "read/write same slot")
   `RR_ASSERT_NOW(a_tail_not_freed, ctl.tail_take, mark_rd_ff != MARK_FREED, "tail set on freed slot")
   `RR_ASSERT_NEXT(a_head_moves, ctl.head_step, head_ff != $past(head_ff), "head did not advance")

endmodule

// File: bench/record_ring_out_of_order_retire_unit_checker.sv
// ----------------------------------------------------------------------------
// record ring checker
// watches both channels, keeps a copy of the slot marks, head and tail, works
// out the result each accepted request word must give and compares it field by
// field with the result words as they are taken, oldest first
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module record_ring_out_of_order_retire_unit_checker #(
   parameter int SLOTS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_stall,
   input  rrooru_pkg::req_type req_data,
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  rrooru_pkg::rsp_type rsp_data,
   output int                  fail_count,
   output int                  pending_count,
   output int                  checked_count
);

   import rrooru_pkg::*;

   logic [1:0] slot_marks [SLOTS];
   logic [7:0] head_ptr;
   logic [7:0] tail_ptr;
   rsp_type    awaited_rsp [$];
   rsp_type    oldest;
   int         mismatches;
   int         compared;

   assign fail_count    = mismatches;
   assign checked_count = compared;

   function automatic logic [7:0] ring_next(logic [7:0] s);
      return (int'(s) + 1 >= SLOTS) ? 8'd0 : s + 8'd1;
   endfunction

   // applies one request word to the ring copy and returns the result it gives
   function automatic rsp_type apply_ring_command(req_type w);
      rsp_type    r;
      logic [7:0] walk;
      logic [1:0] tail_mark;
      logic       done;
      r         = '0;
      tail_mark = slot_marks[tail_ptr];
      case (w.command)
         CMD_SAVE: begin
            r.slot_out           = head_ptr;
            slot_marks[head_ptr] = MARK_NEW;
            head_ptr             = ring_next(head_ptr);
         end
         CMD_RELEASE: begin
            if (int'(w.slot_index) >= SLOTS) begin
               r.status = STATUS_INVALID;
            end else if (w.slot_index != tail_ptr) begin
               if (slot_marks[w.slot_index] == MARK_ABSENT)
                  r.status = STATUS_NOT_FOUND;
               else
                  slot_marks[w.slot_index] = MARK_FREED;
            end else begin
               // retire the tail and every freed slot behind it
               slot_marks[w.slot_index] = MARK_ABSENT;
               walk = ring_next(w.slot_index);
               while (walk != w.slot_index && slot_marks[walk] == MARK_FREED) begin
                  slot_marks[walk] = MARK_ABSENT;
                  walk = ring_next(walk);
               end
               tail_ptr = walk;
            end
         end
         CMD_FIRST: begin
            case (tail_mark)
               MARK_NEW:    r.slot_out = tail_ptr;
               MARK_ABSENT: r.status   = STATUS_NOT_FOUND;
               default:     r.status   = STATUS_NOT_NEW;
            endcase
         end
         CMD_NEXT: begin
            if (int'(w.slot_index) >= SLOTS) begin
               r.status = STATUS_INVALID;
            end else begin
               r.status = STATUS_NOT_FOUND;
               walk     = w.slot_index;
               done     = 1'b0;
               // search ends on the start slot itself, or early on an absent one
               for (int k = 0; k < SLOTS && !done; k++) begin
                  walk = ring_next(walk);
                  if (slot_marks[walk] == MARK_ABSENT) begin
                     done = 1'b1;
                  end else if (slot_marks[walk] == MARK_NEW) begin
                     r.status   = STATUS_OK;
                     r.slot_out = walk;
                     done       = 1'b1;
                  end
               end
            end
         end
         CMD_IS_EMPTY: begin
            case (tail_mark)
               MARK_NEW:    r.ring_empty = 1'b0;
               MARK_ABSENT: r.ring_empty = 1'b1;
               default: begin
                  r.ring_empty = 1'b1;
                  r.status     = STATUS_NOT_NEW;
               end
            endcase
         end
         default: r.status = STATUS_INVALID;
      endcase
      return r;
   endfunction

   task automatic report_mismatch(input string what, input int want, input int got);
      if (mismatches < 40)
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      mismatches++;
   endtask

   initial begin
      mismatches    = 0;
      compared      = 0;
      pending_count = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++)
            slot_marks[i] = MARK_ABSENT;
         head_ptr = '0;
         tail_ptr = '0;
         awaited_rsp.delete();
         pending_count <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_rsp.size() == 0) begin
               report_mismatch("unexpected result word, status", -1, int'(rsp_data.status));
            end else begin
               oldest = awaited_rsp.pop_front();
               compared++;
               if (rsp_data.status !== oldest.status)
                  report_mismatch("status", int'(oldest.status), int'(rsp_data.status));
               if (rsp_data.slot_out !== oldest.slot_out)
                  report_mismatch("slot_out", int'(oldest.slot_out), int'(rsp_data.slot_out));
               if (rsp_data.ring_empty !== oldest.ring_empty)
                  report_mismatch("ring_empty", int'(oldest.ring_empty),
                                  int'(rsp_data.ring_empty));
            end
         end
         if (req_valid && !req_stall)
            awaited_rsp.push_back(apply_ring_command(req_data));
         pending_count <= awaited_rsp.size();
      end
   end

endmodule

// File: bench/record_ring_out_of_order_retire_unit_tb.sv
// ----------------------------------------------------------------------------
// record ring testbench
// directed words over the reset state and the release walk, then random
// commands and fill-and-drain bursts under four sender/receiver idle mixes,
// with one long receiver hold-off; the checker does all the comparing
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module record_ring_out_of_order_retire_unit_tb;

   import rrooru_pkg::*;

   localparam int SLOTS        = 16;
   localparam int PHASE_WORDS  = 450;
   localparam int HOLD_CYCLES  = 300;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   int      fail_count;
   int      pending_count;
   int      checked_count;

   int      tx_idle_pct;
   int      rx_stall_pct;
   int      hold_left;
   int      hold_count;
   int      words_sent;
   int      directed_words;
   int      bursts;
   logic [7:0] head_guess;

   record_ring_out_of_order_retire_unit #(.SLOTS(SLOTS)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   record_ring_out_of_order_retire_unit_checker #(.SLOTS(SLOTS)) checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("%0t: watchdog expired with %0d results outstanding", $time, pending_count);
      $display("Regression FAIL");
      $finish;
   end

   // receiver: long hold-off when asked, otherwise random stalls
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(99) < rx_stall_pct);
         end
      end
   end

   // offers one word, with a random gap first, and returns once it is taken
   task automatic send_word(input logic [2:0] cmd, input logic [7:0] idx);
      int gap;
      gap = 0;
      while (gap < 40 && $urandom_range(99) < tx_idle_pct)
         gap++;
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{command: cmd, slot_index: idx};
      do @(posedge clock); while (req_stall);
      words_sent++;
      if (cmd == CMD_SAVE)
         head_guess = (int'(head_guess) + 1 >= SLOTS) ? 8'd0 : head_guess + 8'd1;
   endtask

   // lets the sender rest until every result is back
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending_count == 0);
   endtask

   // mostly a recently saved slot, sometimes any slot, now and then out of range
   function automatic logic [7:0] pick_slot();
      int pick;
      pick = $urandom_range(99);
      if (pick < 60)
         return 8'((int'(head_guess) + SLOTS - 1 - $urandom_range(5)) % SLOTS);
      else if (pick < 88)
         return 8'($urandom_range(SLOTS - 1));
      else
         return 8'($urandom_range(255));
   endfunction

   task automatic random_word();
      int pick;
      pick = $urandom_range(99);
      if (pick < 28)
         send_word(CMD_SAVE, 8'($urandom_range(255)));
      else if (pick < 58)
         send_word(CMD_RELEASE, pick_slot());
      else if (pick < 68)
         send_word(CMD_FIRST, 8'($urandom_range(255)));
      else if (pick < 83)
         send_word(CMD_NEXT, pick_slot());
      else if (pick < 95)
         send_word(CMD_IS_EMPTY, 8'($urandom_range(255)));
      else
         send_word(3'($urandom_range(7, 5)), 8'($urandom_range(255)));
   endtask

   // saves a run of slots and releases them in shuffled order
   task automatic fill_and_drain();
      logic [7:0] order [SLOTS];
      logic [7:0] swap;
      int         n;
      int         j;
      n = ($urandom_range(3) == 0) ? SLOTS : $urandom_range(2, 8);
      for (int i = 0; i < n; i++) begin
         order[i] = head_guess;
         send_word(CMD_SAVE, 8'($urandom_range(255)));
      end
      for (int i = n - 1; i > 0; i--) begin
         j        = $urandom_range(i);
         swap     = order[i];
         order[i] = order[j];
         order[j] = swap;
      end
      for (int i = 0; i < n; i++) begin
         send_word(CMD_RELEASE, order[i]);
         if ($urandom_range(3) == 0)
            send_word(CMD_NEXT, order[$urandom_range(n - 1)]);
      end
      send_word(CMD_FIRST, 8'($urandom_range(255)));
      send_word(CMD_IS_EMPTY, 8'($urandom_range(255)));
      bursts++;
   endtask

   initial begin
      int goal;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      tx_idle_pct  = 0;
      rx_stall_pct = 0;
      hold_left    = 0;
      hold_count   = 0;
      words_sent   = 0;
      bursts       = 0;
      head_guess   = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty ring, bad indexes and bad codes
      send_word(CMD_IS_EMPTY, 8'h00);
      send_word(CMD_FIRST,    8'hFF);
      send_word(CMD_NEXT,     8'h00);
      send_word(CMD_RELEASE,  8'h03);
      send_word(CMD_RELEASE,  8'h10);
      send_word(CMD_RELEASE,  8'hFF);
      send_word(CMD_NEXT,     8'hFF);
      send_word(CMD_NEXT,     8'h10);
      send_word(3'd5, 8'hAA);
      send_word(3'd6, 8'h55);
      send_word(3'd7, 8'hFF);
      // out-of-order release, next skipping a freed slot, tail walk
      send_word(CMD_SAVE,     8'h00);
      send_word(CMD_SAVE,     8'hFF);
      send_word(CMD_SAVE,     8'h00);
      send_word(CMD_FIRST,    8'h00);
      send_word(CMD_RELEASE,  8'h01);
      send_word(CMD_NEXT,     8'h00);
      send_word(CMD_NEXT,     8'h02);
      send_word(CMD_RELEASE,  8'h00);
      send_word(CMD_IS_EMPTY, 8'h00);
      send_word(CMD_RELEASE,  8'h02);
      send_word(CMD_FIRST,    8'h00);
      directed_words = words_sent;
      drain_results();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
            1: begin tx_idle_pct = 46; rx_stall_pct = 0;  end
            2: begin tx_idle_pct = 0;  rx_stall_pct = 46; end
            default: begin tx_idle_pct = 36; rx_stall_pct = 36; end
         endcase
         goal = words_sent + PHASE_WORDS;
         while (words_sent < goal) begin
            // receiver goes quiet while words keep coming
            if (phase == 0 && words_sent >= directed_words + 20 && hold_left == 0
                && hold_count == 0) begin
               hold_left = HOLD_CYCLES;
               hold_count++;
               fill_and_drain();
            end else if ($urandom_range(9) == 0) begin
               fill_and_drain();
            end else begin
               random_word();
            end
         end
         drain_results();
      end

      repeat (SLOTS + 4) @(posedge clock);
      $display("covered %0d request words (%0d directed, %0d fill-and-drain bursts)",
               words_sent, directed_words, bursts);
      $display("compared %0d results across four idle mixes and a %0d-cycle hold-off",
               checked_count, HOLD_CYCLES);
      if (fail_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+src
src/rrooru_pkg.sv
src/rrooru_ctrl.sv
src/rrooru_datapath.sv
src/record_ring_out_of_order_retire_unit.sv
bench/record_ring_out_of_order_retire_unit_checker.sv
bench/record_ring_out_of_order_retire_unit_tb.sv
